FILE: src/csf_pkg.sv
// Shared codes, widths and payload constants of the counting semaphore block.
package csf_pkg;

   // Widths of the channel payload fields.
   localparam int OP_W      = 2;
   localparam int TID_W     = 8;
   localparam int OUTCOME_W = 3;
   localparam int COUNT_W   = 16;
   localparam int ID_WIDE_W = 16;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register indexes.
   localparam logic REG_INITIAL_COUNT = 1'b0;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WAIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
   localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // Outcome codes.
   localparam logic [OUTCOME_W-1:0] OUT_GRANTED      = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_BLOCKED      = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_QUEUE_FULL   = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_COUNT_RAISED = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_RELEASED     = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_CLOSED_EMPTY = 3'd5;
   localparam logic [OUTCOME_W-1:0] OUT_SATURATED    = 3'd6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

FILE: src/csf_req_if.sv
// Request channel interface: operation and calling thread id.
interface csf_req_if;
   logic                         valid;
   logic                         ready;
   logic [csf_pkg::OP_W-1:0]     operation;
   logic [csf_pkg::TID_W-1:0]    thread_id;

   modport source (output valid, output operation, output thread_id, input ready);
   modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

FILE: src/csf_rsp_if.sv
// Response channel interface: outcome, woken thread id and last flag.
interface csf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [csf_pkg::OUTCOME_W-1:0]   outcome;
   logic [csf_pkg::TID_W-1:0]       woken_thread;
   logic                            last;

   modport source (output valid, output outcome, output woken_thread, output last,
                   input ready);
   modport sink   (input valid, input outcome, input woken_thread, input last,
                   output ready);
endinterface

FILE: src/counting_semaphore_fifo_wait.sv
// Counting semaphore with a ring-buffer FIFO of blocked thread ids in a RAM.
// Flow: a request beat is taken in IDLE; EXEC retires it into the output register,
//   provided the output register is free.
// Throughput: a new request is not taken until the last one retires; a close releases
//   one waiter per cycle while the output register is free. The RAM read is registered.
// Reset (synchronous, active high): count and initial_count go to zero, the queue
//   empties and the output valid clears; the RAM is not cleared and needs no pass.
module counting_semaphore_fifo_wait #(
   parameter int QUEUE_DEPTH    = 64,
   parameter int THREAD_ID_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   csf_req_if.sink                         req_bus,
   csf_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [csf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [csf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [csf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   // Ring index and occupancy widths follow from the queue depth.
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [TOT_W-1:0] TOT_FULL = TOT_W'(QUEUE_DEPTH);
   localparam logic [TOT_W-1:0] TOT_ONE  = TOT_W'(1);

   // Sequencer: IDLE takes a request beat and issues the head read; EXEC has the
   // head entry in hand and retires the operation. A close stays in EXEC and
   // releases one waiter per cycle, while the output register is free, until the queue is empty.
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                          state_ff, state_in;
   logic [csf_pkg::COUNT_W-1:0]   initial_count_ff, initial_count_in;
   logic [csf_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              tail_ff, tail_in;
   logic [TOT_W-1:0]              total_ff, total_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Latched request payload and output payload; these carry no reset.
   logic [csf_pkg::OP_W-1:0]      op_ff;
   logic [THREAD_ID_BITS-1:0]     tid_ff;
   logic [csf_pkg::OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic [csf_pkg::TID_W-1:0]     woken_ff, woken_in;
   logic                          last_ff, last_in;

   logic                          req_fire;
   logic                          out_free;
   logic                          rsp_load;
   logic                          pop;
   logic                          wr_en;
   logic                          csr_write;
   logic [IDX_W-1:0]              head_next;
   logic [IDX_W-1:0]              tail_next;
   logic [IDX_W-1:0]              rd_addr;
   logic [THREAD_ID_BITS-1:0]     rd_data;
   logic [csf_pkg::ID_WIDE_W-1:0] tid_wide;
   logic [csf_pkg::ID_WIDE_W-1:0] rd_wide;

   // Configuration port. Every address with paddr[2] clear maps to the register;
   // writes to the other addresses are accepted and dropped.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & (paddr[2] == csf_pkg::REG_INITIAL_COUNT);
   assign prdata    = (paddr[2] == csf_pkg::REG_INITIAL_COUNT)
                    ? csf_pkg::CSR_DATA_W'(initial_count_ff) : '0;
   assign initial_count_in = csr_write ? pwdata[csf_pkg::COUNT_W-1:0] : initial_count_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;

   // The output register can load when it is empty or its beat leaves this cycle.
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;

   // Thread ids are kept to THREAD_ID_BITS bits on the way in and shown as
   // eight bits on the way out.
   assign tid_wide = csf_pkg::ID_WIDE_W'(req_bus.thread_id);
   assign rd_wide  = csf_pkg::ID_WIDE_W'(rd_data);

   assign head_next = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;

   // The read port always looks at the oldest waiter. When the head pops this
   // cycle it looks one slot ahead instead, so a close can drain at one waiter
   // per cycle while the output register is free. A write only happens in EXEC and the next
   // read of that slot is issued no earlier than the following cycle, so no bypass is needed.
   assign rd_addr = pop ? head_next : head_ff;

   csf_ram #(
      .WIDTH (THREAD_ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (tid_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      total_in   = total_ff;
      rsp_load   = 1'b0;
      outcome_in = csf_pkg::OUT_GRANTED;
      woken_in   = '0;
      last_in    = 1'b1;
      pop        = 1'b0;
      wr_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == csf_pkg::OP_NONE) begin
               // The unused code gives no result and touches no state.
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  csf_pkg::OP_WAIT: begin
                     if (count_ff != '0) begin
                        count_in   = count_ff - 1'b1;
                        outcome_in = csf_pkg::OUT_GRANTED;
                     end else if (total_ff >= TOT_FULL) begin
                        outcome_in = csf_pkg::OUT_QUEUE_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        tail_in    = tail_next;
                        total_in   = total_ff + 1'b1;
                        outcome_in = csf_pkg::OUT_BLOCKED;
                     end
                  end
                  csf_pkg::OP_SIGNAL: begin
                     if (total_ff != '0) begin
                        pop        = 1'b1;
                        head_in    = head_next;
                        total_in   = total_ff - 1'b1;
                        outcome_in = csf_pkg::OUT_RELEASED;
                        woken_in   = rd_wide[csf_pkg::TID_W-1:0];
                     end else if (count_ff == csf_pkg::COUNT_MAX) begin
                        outcome_in = csf_pkg::OUT_SATURATED;
                     end else begin
                        count_in   = count_ff + 1'b1;
                        outcome_in = csf_pkg::OUT_COUNT_RAISED;
                     end
                  end
                  csf_pkg::OP_CLOSE: begin
                     if (total_ff == '0) begin
                        outcome_in = csf_pkg::OUT_CLOSED_EMPTY;
                     end else begin
                        pop        = 1'b1;
                        outcome_in = csf_pkg::OUT_RELEASED;
                        woken_in   = rd_wide[csf_pkg::TID_W-1:0];
                        last_in    = (total_ff == TOT_ONE);
                        head_in    = head_next;
                        total_in   = total_ff - 1'b1;
                        if (!last_in) begin
                           state_in = S_EXEC;
                        end
                     end
                     // The final beat of a close empties the ring and reloads the count.
                     if (last_in) begin
                        head_in  = '0;
                        tail_in  = '0;
                        total_in = '0;
                        count_in = initial_count_ff;
                     end
                  end
                  default: begin
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         initial_count_ff <= '0;
         count_ff         <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         total_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         initial_count_ff <= initial_count_in;
         count_ff         <= count_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         total_ff         <= total_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_bus.operation;
         tid_ff <= tid_wide[THREAD_ID_BITS-1:0];
      end
      if (rsp_load) begin
         outcome_ff <= outcome_in;
         woken_ff   <= woken_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.outcome      = outcome_ff;
   assign rsp_bus.woken_thread = woken_ff;
   assign rsp_bus.last         = last_ff;

   // The ring never holds more waiters than it has slots.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_FULL)
      else $error("waiter total exceeds queue depth");

   // The count only moves while an operation retires.
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(count_ff))
      else $error("count changed while idle");

   // Only a close that still has waiters left produces a beat without last.
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !last_in) |-> (op_ff == csf_pkg::OP_CLOSE &&
                                  outcome_in == csf_pkg::OUT_RELEASED))
      else $error("non-final beat outside a close drain");

   // After the final beat of a close the ring is empty and rewound.
   a_close_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && op_ff == csf_pkg::OP_CLOSE && last_in) |=>
         (total_ff == '0 && head_ff == '0 && tail_ff == '0))
      else $error("queue not empty after close");

   // A thread is queued only at zero count with room left in the ring.
   a_enqueue_ok: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff == '0 && total_ff < TOT_FULL))
      else $error("enqueue with nonzero count or full queue");

endmodule

FILE: src/csf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module csf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
